FILE: hw/rtl/sefr_pkg.sv
// Package: shared types and codes for the STX/ETX frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sefr_pkg;

    // Largest payload length a frame may announce
    localparam int MAX_DATA_LEN = 256;

    // Item kinds on the input channel
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds on the output channel
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Frame end status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_BAD_CHECK = 3'd4
    } t_status;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_START   = 2'd1,
        REG_END     = 2'd2
    } t_reg_idx;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  dest_address;
        logic [7:0]  frame_type;
        logic [7:0]  function_code;
        logic [15:0] data_length;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

endpackage
`default_nettype wire

FILE: hw/rtl/sefr_if.sv
// Interfaces: input, output and configuration channels of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface sefr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface sefr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  dest_address;
    logic [7:0]  frame_type;
    logic [7:0]  function_code;
    logic [15:0] data_length;
    logic [2:0]  status;
    logic        last;
    modport source (output valid, output kind, output data_byte, output data_index,
                    output dest_address, output frame_type, output function_code,
                    output data_length, output status, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input data_index,
                    input dest_address, input frame_type, input function_code,
                    input data_length, input status, input last, output ready);
endinterface

interface sefr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sefr_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stx_etx_xor_frame_receiver_unit.sv
// Top level: STX/ETX frame receiver with XOR block check and frame status.
//
//   port    dir  items
//   i_in    in   mode (byte or ms tick), rx_byte
//   o_out   out  data byte results and frame end results with status
//   i_cfg   in   register writes: timeout_ticks, start_code, end_code
//
// One item per cycle while the skid stage is empty: an accepted item updates
// the frame state at its accepting edge. A result, if any, is loaded at that
// edge into a free output register and offered on o_out from the next cycle.
// A one-entry skid stage behind the output register takes a result when it is
// held, keeping input ready; input stalls only when both hold results.
// Synchronous active-low reset returns to hunting with default registers.
`timescale 1ns / 1ps
`default_nettype none
module stx_etx_xor_frame_receiver_unit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sefr_in_if.sink         i_in,
    sefr_out_if.source      o_out,
    sefr_cfg_if.sink        i_cfg
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_END
    } t_phase;

    // Configuration registers
    logic [15:0] r_timeout;
    logic [7:0]  r_start;
    logic [7:0]  r_end;

    // Frame state
    t_phase      r_phase,    n_phase;
    logic [2:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [7:0]  r_addr,     n_addr;
    logic [7:0]  r_type,     n_type;
    logic [7:0]  r_code,     n_code;
    logic [15:0] r_length,   n_length;
    logic [8:0]  r_data_cnt, n_data_cnt;
    logic [7:0]  r_xor,      n_xor;
    logic [7:0]  r_check,    n_check;
    logic [15:0] r_elapsed,  n_elapsed;

    // Output register and skid stage
    sefr_pkg::t_out_item r_out, r_skid, res;
    logic                r_out_v, r_skid_v;
    logic                has_res;
    logic                in_fire;
    logic                out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_v;
    assign in_fire     = i_in.valid && !r_skid_v;
    assign out_free    = !r_out_v || o_out.ready;

    // Apply register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd1000;
            r_start   <= 8'd2;
            r_end     <= 8'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sefr_pkg::REG_TIMEOUT: r_timeout <= i_cfg.data;
                sefr_pkg::REG_START:   r_start   <= i_cfg.data[7:0];
                sefr_pkg::REG_END:     r_end     <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Advance the frame state for one accepted item
    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_addr     = r_addr;
        n_type     = r_type;
        n_code     = r_code;
        n_length   = r_length;
        n_data_cnt = r_data_cnt;
        n_xor      = r_xor;
        n_check    = r_check;
        n_elapsed  = r_elapsed;
        has_res    = 1'b0;
        res        = '0;
        res.kind   = sefr_pkg::KIND_END;
        res.last   = 1'b1;
        res.status = sefr_pkg::ST_OK;

        if (in_fire) begin
            if (i_in.mode == sefr_pkg::MODE_TICK) begin
                if (r_phase != PH_HUNT) begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (n_elapsed >= r_timeout) begin
                        has_res    = 1'b1;
                        res.status = sefr_pkg::ST_TIMEOUT;
                        n_phase    = PH_HUNT;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_in.rx_byte == r_start) begin
                            n_hdr_cnt  = '0;
                            n_addr     = '0;
                            n_type     = '0;
                            n_code     = '0;
                            n_length   = '0;
                            n_data_cnt = '0;
                            n_check    = '0;
                            n_xor      = i_in.rx_byte;
                            n_elapsed  = '0;
                            n_phase    = PH_HEADER;
                            // zero timeout closes the frame at once
                            if (r_timeout == 16'd0) begin
                                has_res    = 1'b1;
                                res.status = sefr_pkg::ST_TIMEOUT;
                                n_phase    = PH_HUNT;
                            end
                        end
                    end
                    PH_HEADER: begin
                        n_xor = r_xor ^ i_in.rx_byte;
                        case (r_hdr_cnt)
                            3'd0:    n_addr   = i_in.rx_byte;
                            3'd1:    n_type   = i_in.rx_byte;
                            3'd2:    n_code   = i_in.rx_byte;
                            3'd3:    n_length = {8'd0, i_in.rx_byte};
                            default: n_length = {i_in.rx_byte, r_length[7:0]};
                        endcase
                        if (r_hdr_cnt < 3'd4) begin
                            n_hdr_cnt = r_hdr_cnt + 3'd1;
                        end else begin
                            n_hdr_cnt  = '0;
                            n_data_cnt = '0;
                            if (n_length > 16'(sefr_pkg::MAX_DATA_LEN)) begin
                                has_res    = 1'b1;
                                res.status = sefr_pkg::ST_TOO_LONG;
                                n_phase    = PH_HUNT;
                            end else if (n_length == 16'd0) begin
                                n_phase = PH_CHECK;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_xor      = r_xor ^ i_in.rx_byte;
                        n_data_cnt = r_data_cnt + 9'd1;
                        if ({7'd0, n_data_cnt} >= r_length) begin
                            n_phase = PH_CHECK;
                        end
                        has_res        = 1'b1;
                        res.kind       = sefr_pkg::KIND_DATA;
                        res.last       = 1'b0;
                        res.data_byte  = i_in.rx_byte;
                        res.data_index = r_data_cnt[7:0];
                    end
                    PH_CHECK: begin
                        n_check = i_in.rx_byte;
                        n_phase = PH_END;
                    end
                    default: begin
                        // end code mismatch wins over a checksum mismatch
                        has_res = 1'b1;
                        n_phase = PH_HUNT;
                        if (i_in.rx_byte != r_end) begin
                            res.status = sefr_pkg::ST_BAD_END;
                        end else if (r_xor != r_check) begin
                            res.status = sefr_pkg::ST_BAD_CHECK;
                        end
                    end
                endcase
            end
        end

        res.dest_address  = n_addr;
        res.frame_type    = n_type;
        res.function_code = n_code;
        res.data_length   = n_length;
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_hdr_cnt  <= '0;
            r_addr     <= '0;
            r_type     <= '0;
            r_code     <= '0;
            r_length   <= '0;
            r_data_cnt <= '0;
            r_xor      <= '0;
            r_check    <= '0;
            r_elapsed  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_addr     <= n_addr;
            r_type     <= n_type;
            r_code     <= n_code;
            r_length   <= n_length;
            r_data_cnt <= n_data_cnt;
            r_xor      <= n_xor;
            r_check    <= n_check;
            r_elapsed  <= n_elapsed;
        end
    end

    // Load output register, park a result in the skid stage when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= has_res;
            end
        end else if (has_res) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (has_res) begin
            r_skid <= res;
        end
    end

    // Drive the output channel
    assign o_out.valid         = r_out_v;
    assign o_out.kind          = r_out.kind;
    assign o_out.data_byte     = r_out.data_byte;
    assign o_out.data_index    = r_out.data_index;
    assign o_out.dest_address  = r_out.dest_address;
    assign o_out.frame_type    = r_out.frame_type;
    assign o_out.function_code = r_out.function_code;
    assign o_out.data_length   = r_out.data_length;
    assign o_out.status        = r_out.status;
    assign o_out.last          = r_out.last;

endmodule
`default_nettype wire

FILE: tb/stx_etx_xor_frame_receiver_unit_tb.sv
// Testbench: byte and tick items into the STX/ETX frame receiver, each result checked.
`timescale 1ns / 1ps
`default_nettype none
module stx_etx_xor_frame_receiver_unit_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [sefr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [2:0] {RX_HUNT, RX_HEADER, RX_DATA, RX_CHECK, RX_TAIL} t_rx_phase;
    typedef logic [7:0] t_byte_q [$];

    logic i_clk;
    logic i_rst_n;

    sefr_in_if  in_ch ();
    sefr_out_if out_ch ();
    sefr_cfg_if cfg_ch ();

    stx_etx_xor_frame_receiver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow registers and frame state of the receiver, as after reset
    logic [15:0] timeout_lim = 16'd1000;
    logic [7:0]  start_byte  = 8'd2;
    logic [7:0]  end_byte    = 8'd3;
    t_rx_phase   rx_phase    = RX_HUNT;
    logic [2:0]  hdr_idx     = '0;
    logic [7:0]  hdr_addr    = '0;
    logic [7:0]  hdr_type    = '0;
    logic [7:0]  hdr_code    = '0;
    logic [15:0] hdr_len     = '0;
    logic [8:0]  data_cnt    = '0;
    logic [7:0]  xor_acc     = '0;
    logic [7:0]  chk_rx      = '0;
    logic [15:0] tick_cnt    = '0;

    sefr_pkg::t_out_item pending_results [$];
    sefr_pkg::t_out_item want_item;
    int          fail_count     = 0;
    int          items_sent     = 0;
    int          stall_left     = 0;
    int          idle_cycles    = 0;
    bit          bursty         = 1'b1;
    bit          big_frame_sent = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Build a result item around the header received so far
    function automatic sefr_pkg::t_out_item frame_result(input logic kind,
                                                         input logic [7:0] b,
                                                         input logic [7:0] idx,
                                                         input sefr_pkg::t_status st);
        sefr_pkg::t_out_item r;
        r.kind          = kind;
        r.data_byte     = b;
        r.data_index    = idx;
        r.dest_address  = hdr_addr;
        r.frame_type    = hdr_type;
        r.function_code = hdr_code;
        r.data_length   = hdr_len;
        r.status        = st;
        r.last          = kind;
        return r;
    endfunction

    // End the frame with a status and go back to hunting
    function automatic bit close_frame(input sefr_pkg::t_status st,
                                       output sefr_pkg::t_out_item res);
        res = frame_result(sefr_pkg::KIND_END, 8'h00, 8'h00, st);
        rx_phase = RX_HUNT;
        return 1'b1;
    endfunction

    // Advance the frame state by one item; return 1 when it yields a result
    function automatic bit frame_state_step(input logic mode, input logic [7:0] b,
                                            output sefr_pkg::t_out_item res);
        logic [7:0] idx;
        res = '0;
        if (mode == sefr_pkg::MODE_TICK) begin
            if (rx_phase == RX_HUNT) return 1'b0;
            if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= timeout_lim) return close_frame(sefr_pkg::ST_TIMEOUT, res);
            return 1'b0;
        end
        case (rx_phase)
            RX_HUNT: begin
                if (b != start_byte) return 1'b0;
                hdr_idx  = '0;
                hdr_addr = '0;
                hdr_type = '0;
                hdr_code = '0;
                hdr_len  = '0;
                data_cnt = '0;
                chk_rx   = '0;
                xor_acc  = b;
                tick_cnt = '0;
                rx_phase = RX_HEADER;
                if (timeout_lim == 16'd0) return close_frame(sefr_pkg::ST_TIMEOUT, res);
                return 1'b0;
            end
            RX_HEADER: begin
                xor_acc ^= b;
                case (hdr_idx)
                    3'd0:    hdr_addr = b;
                    3'd1:    hdr_type = b;
                    3'd2:    hdr_code = b;
                    3'd3:    hdr_len  = {8'h00, b};
                    default: hdr_len  = {b, hdr_len[7:0]};
                endcase
                if (hdr_idx < 3'd4) begin
                    hdr_idx = hdr_idx + 3'd1;
                    return 1'b0;
                end
                hdr_idx = '0;
                if (hdr_len > 16'(sefr_pkg::MAX_DATA_LEN))
                    return close_frame(sefr_pkg::ST_TOO_LONG, res);
                data_cnt = '0;
                rx_phase = (hdr_len == 16'd0) ? RX_CHECK : RX_DATA;
                return 1'b0;
            end
            RX_DATA: begin
                idx = data_cnt[7:0];
                xor_acc ^= b;
                data_cnt = data_cnt + 9'd1;
                if ({7'd0, data_cnt} >= hdr_len) rx_phase = RX_CHECK;
                res = frame_result(sefr_pkg::KIND_DATA, b, idx, sefr_pkg::ST_OK);
                return 1'b1;
            end
            RX_CHECK: begin
                chk_rx = b;
                rx_phase = RX_TAIL;
                return 1'b0;
            end
            default: begin
                // a wrong end code hides a wrong check byte
                if (b != end_byte) return close_frame(sefr_pkg::ST_BAD_END, res);
                if (xor_acc != chk_rx) return close_frame(sefr_pkg::ST_BAD_CHECK, res);
                return close_frame(sefr_pkg::ST_OK, res);
            end
        endcase
    endfunction

    // Assemble start code, header, payload, XOR check byte and end code
    function automatic t_byte_q build_frame(input logic [7:0] addr, input logic [7:0] ftype,
                                            input logic [7:0] fcode, input logic [15:0] len,
                                            input t_byte_q payload);
        t_byte_q q;
        logic [7:0] chk;
        q = {start_byte, addr, ftype, fcode, len[7:0], len[15:8]};
        foreach (payload[i]) q.push_back(payload[i]);
        chk = '0;
        foreach (q[i]) chk ^= q[i];
        q.push_back(chk);
        q.push_back(end_byte);
        return q;
    endfunction

    // Send one item, with an optional idle burst ahead of it
    task automatic send_item(input logic mode, input logic [7:0] b);
        sefr_pkg::t_out_item res;
        int gap;
        if (bursty && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (frame_state_step(mode, b, res)) pending_results.push_back(res);
        items_sent++;
    endtask

    // Send a byte sequence, sprinkling ticks in between
    task automatic send_bytes(input t_byte_q q, input int tick_pct);
        foreach (q[i]) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(sefr_pkg::MODE_TICK, 8'($urandom));
            send_item(sefr_pkg::MODE_BYTE, q[i]);
        end
    endtask

    // Write a register once the receiver has gone quiet
    task automatic write_reg(input logic [sefr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            sefr_pkg::REG_TIMEOUT: timeout_lim = value;
            sefr_pkg::REG_START:   start_byte  = value[7:0];
            sefr_pkg::REG_END:     end_byte    = value[7:0];
            default:     ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest expected one; stall the output at random
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation: kind %0d, data_byte 0x%0h, status %0d",
                           out_ch.kind, out_ch.data_byte, out_ch.status);
                    fail_count++;
                end else begin
                    want_item = pending_results.pop_front();
                    check_field("kind", 16'(want_item.kind), 16'(out_ch.kind));
                    check_field("data_byte", 16'(want_item.data_byte),
                                16'(out_ch.data_byte));
                    check_field("data_index", 16'(want_item.data_index),
                                16'(out_ch.data_index));
                    check_field("dest_address", 16'(want_item.dest_address),
                                16'(out_ch.dest_address));
                    check_field("frame_type", 16'(want_item.frame_type),
                                16'(out_ch.frame_type));
                    check_field("function_code", 16'(want_item.function_code),
                                16'(out_ch.function_code));
                    check_field("data_length", want_item.data_length, out_ch.data_length);
                    check_field("status", 16'(want_item.status), 16'(out_ch.status));
                    check_field("last", 16'(want_item.last), 16'(out_ch.last));
                end
            end
            if (!bursty) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Default registers: a tick and noise while hunting, then a clean frame
    task automatic test_defaults_frame();
        t_byte_q body;
        body = {8'hFF, 8'h00};
        send_item(sefr_pkg::MODE_TICK, 8'hFF);
        send_item(sefr_pkg::MODE_BYTE, 8'h00);
        send_bytes(build_frame(8'hFF, 8'h00, 8'h80, 16'd2, body), 0);
    endtask

    // Corrupt the tail: both wrong, then only the check byte wrong
    task automatic test_bad_tail();
        t_byte_q frame, body;
        frame = build_frame(8'h12, 8'h34, 8'h56, 16'd0, body);
        frame[frame.size()-2] ^= 8'h5A;
        frame[frame.size()-1] ^= 8'hC3;
        send_bytes(frame, 0);
        body = {8'h7E};
        frame = build_frame(8'h00, 8'hFF, 8'h01, 16'd1, body);
        frame[frame.size()-2] ^= 8'h01;
        send_bytes(frame, 0);
    endtask

    // Length one above the limit closes right after the header
    task automatic test_too_long();
        t_byte_q body;
        send_bytes(build_frame(8'hAA, 8'h55, 8'h0F, 16'(sefr_pkg::MAX_DATA_LEN + 1), body), 0);
    endtask

    // Tick limit: normal expiry, a limit lowered mid-frame, and a zero limit
    task automatic test_timeout();
        write_reg(sefr_pkg::REG_TIMEOUT, 16'd2);
        send_item(sefr_pkg::MODE_BYTE, start_byte);
        send_item(sefr_pkg::MODE_TICK, 8'h00);
        send_item(sefr_pkg::MODE_TICK, 8'hFF);
        write_reg(sefr_pkg::REG_TIMEOUT, 16'd1000);
        send_item(sefr_pkg::MODE_BYTE, start_byte);
        send_item(sefr_pkg::MODE_TICK, 8'h00);
        write_reg(sefr_pkg::REG_TIMEOUT, 16'd1);
        send_item(sefr_pkg::MODE_TICK, 8'h00);
        write_reg(sefr_pkg::REG_TIMEOUT, 16'd0);
        send_item(sefr_pkg::MODE_BYTE, start_byte);
        send_item(sefr_pkg::MODE_TICK, 8'h00);
    endtask

    // Extreme register values, ignored upper data bits and an unused index
    task automatic test_register_extremes();
        t_byte_q body;
        write_reg(sefr_pkg::REG_TIMEOUT, 16'hFFFF);
        write_reg(sefr_pkg::REG_START, 16'hA5FF);
        write_reg(sefr_pkg::REG_END, 16'h0000);
        write_reg(REG_UNUSED, 16'h1234);
        body = {8'h80};
        send_bytes(build_frame(8'h01, 8'h02, 8'h03, 16'd1, body), 0);
        write_reg(sefr_pkg::REG_START, 16'h0000);
        write_reg(sefr_pkg::REG_END, 16'h00FF);
        body.delete();
        send_bytes(build_frame(8'hFF, 8'hFF, 8'hFF, 16'd0, body), 0);
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic test_random_frames(input int n_items);
        t_byte_q frame, body;
        int stop_at, pick, len, keep;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // reconfigure now and then
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)       write_reg(sefr_pkg::REG_TIMEOUT, 16'd0);
                else if (pick < 40) write_reg(sefr_pkg::REG_TIMEOUT,
                                              16'($urandom_range(1, 30)));
                else if (pick < 85) write_reg(sefr_pkg::REG_TIMEOUT, 16'd1000);
                else                write_reg(sefr_pkg::REG_TIMEOUT, 16'($urandom));
                write_reg(sefr_pkg::REG_START, 16'($urandom));
                write_reg(sefr_pkg::REG_END, 16'($urandom));
            end
            // pick a length: mostly short, one full-size frame, some too long
            pick = $urandom_range(0, 99);
            if (pick < 80)       len = $urandom_range(0, 12);
            else if (pick < 90)  len = $urandom_range(13, 40);
            else if (pick < 95)  len = $urandom_range(sefr_pkg::MAX_DATA_LEN + 1, 65535);
            else if (!big_frame_sent) begin
                len = sefr_pkg::MAX_DATA_LEN;
                big_frame_sent = 1'b1;
            end else begin
                len = $urandom_range(0, 3);
            end
            body.delete();
            repeat ((len > sefr_pkg::MAX_DATA_LEN) ? 0 : len) body.push_back(8'($urandom));
            frame = build_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'(len), body);
            // damage some frames
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                frame[frame.size()-2] ^= 8'($urandom_range(1, 255));
            end else if (pick < 20) begin
                frame[frame.size()-1] ^= 8'($urandom_range(1, 255));
            end else if (pick < 30) begin
                keep = $urandom_range(1, frame.size() - 1);
                while (frame.size() > keep) void'(frame.pop_back());
            end
            send_bytes(frame, $urandom_range(0, 25));
            if (pick >= 90) begin
                repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
            end
        end
    endtask

    // Reset, directed tests, random traffic, then drain and report
    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= sefr_pkg::MODE_BYTE;
        in_ch.rx_byte <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= sefr_pkg::REG_TIMEOUT;
        cfg_ch.data   <= 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_frame();
        test_bad_tail();
        test_too_long();
        test_timeout();
        test_register_extremes();
        test_random_frames(460);
        bursty = 1'b0;
        test_random_frames(240);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
